// ----- src/sarq_pkg.sv -----
// ============================================================================
// sarq_pkg
// Shared types and constants for the shortest-arc quaternion pipeline.
// ============================================================================
package sarq_pkg;

    // Default number of fraction bits of the Q1.x fixed-point fields.
    localparam int FRAC_BITS_DEF = 14;

    // Width of an input or output vector component.
    localparam int COMP_W = 16;

    // Width of a component magnitude once scaled below 2^31.
    localparam int MAG_W = 31;

    // Width of the sum of four squared magnitudes.
    localparam int L2_W = 64;

    // Width of the integer square root of that sum.
    localparam int ROOT_W = 32;

    // Number of quaternion components.
    localparam int NUM_LANES = 4;

    // Scaled magnitudes of the four quaternion components (x, y, z, w).
    typedef logic [NUM_LANES-1:0][MAG_W-1:0] mag_vec_t;

    // Per-item flags that travel beside the data.
    typedef struct packed {
        logic [NUM_LANES-1:0] neg;   // component is negative
        logic                 anti;  // perpendicular fallback axis was used
        logic                 ok;    // squared length above the threshold
    } side_t;

endpackage

// ----- src/shortest_arc_quaternion_unit.sv -----
// ============================================================================
// shortest_arc_quaternion_unit
// Unit quaternion that rotates one Q1.x direction vector onto another.
// ============================================================================
// The unit takes one vector pair per clock and gives one quaternion per
// clock, in order, unless the output stalls. From acceptance to the output
// register an item passes eight front stages for the products, the
// threshold tests and the sum of squares, 32 stages of the square root
// (one root bit each), and a rounded numerator stage plus FRAC_BITS + 1
// divider stages (one quotient bit each). The whole pipeline holds while a
// result in the output register is stalled; an item is accepted whenever
// the output register is empty or being taken. min_length_sq may be
// written only while no item is in flight.
module shortest_arc_quaternion_unit #(
    parameter int FRAC_BITS = sarq_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] from_x,
    input  logic [15:0] from_y,
    input  logic [15:0] from_z,
    input  logic [15:0] to_x,
    input  logic [15:0] to_y,
    input  logic [15:0] to_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] quat_x,
    output logic [15:0] quat_y,
    output logic [15:0] quat_z,
    output logic [15:0] quat_w,
    output logic        anti_parallel
);
    import sarq_pkg::*;

    localparam int NQ = FRAC_BITS + 1;
    localparam logic [NQ-1:0] ONE = NQ'(1) << FRAC_BITS;

    logic               en;
    logic [15:0]        min_length_sq_reg;
    logic               out_valid_reg;
    logic [15:0]        quat_reg [NUM_LANES];
    logic               anti_reg;

    logic               fr_valid;
    mag_vec_t           fr_mag;
    logic [L2_W-1:0]    fr_l2;
    side_t              fr_side;

    logic               sq_valid;
    logic [ROOT_W-1:0]  sq_len;
    mag_vec_t           sq_mag;
    side_t              sq_side;

    logic                             dv_valid;
    logic [NUM_LANES-1:0][NQ-1:0]     dv_quot;
    logic                             dv_len_zero;
    side_t                            dv_side;

    logic [15:0]        quat_next [NUM_LANES];

    // Pipeline advances unless a finished item is held at the output.
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_sq_reg <= 16'd1;
        end
        else if (cfg_wr_en)
        begin
            min_length_sq_reg <= cfg_wr_data;
        end
    end

    sarq_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (in_valid),
        .a_in          ({from_z, from_y, from_x}),
        .b_in          ({to_z, to_y, to_x}),
        .min_length_sq (min_length_sq_reg),
        .out_valid     (fr_valid),
        .out_mag       (fr_mag),
        .out_l2        (fr_l2),
        .out_side      (fr_side)
    );

    sarq_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_l2     (fr_l2),
        .in_mag    (fr_mag),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_len   (sq_len),
        .out_mag   (sq_mag),
        .out_side  (sq_side)
    );

    sarq_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (sq_valid),
        .in_len       (sq_len),
        .in_mag       (sq_mag),
        .in_side      (sq_side),
        .out_valid    (dv_valid),
        .out_quot     (dv_quot),
        .out_len_zero (dv_len_zero),
        .out_side     (dv_side)
    );

    // Clip, apply the sign, and zero degenerate results.
    always_comb
    begin
        logic [NQ-1:0] r;
        logic [31:0]   r32;
        logic [31:0]   lim;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            r   = (dv_quot[l] > ONE) ? ONE : dv_quot[l];
            r32 = 32'(r);
            lim = dv_side.neg[l] ? 32'd32768 : 32'd32767;
            if (r32 > lim)
            begin
                r32 = lim;
            end
            if (!dv_side.ok || dv_len_zero)
            begin
                quat_next[l] = '0;
            end
            else
            begin
                quat_next[l] = dv_side.neg[l] ? 16'(-r32) : r32[15:0];
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && dv_valid)
        begin
            quat_reg <= quat_next;
            anti_reg <= dv_side.anti;
        end
    end

    assign out_valid     = out_valid_reg;
    assign quat_x        = quat_reg[0];
    assign quat_y        = quat_reg[1];
    assign quat_z        = quat_reg[2];
    assign quat_w        = quat_reg[3];
    assign anti_parallel = anti_reg;

endmodule

// ----- src/sarq_front.sv -----
// ============================================================================
// sarq_front
// Front end: half-vector products, branch choice, threshold test, scaling
// of the component magnitudes and their sum of squares. Eight stages.
// ============================================================================
module sarq_front #(
    parameter int FRAC_BITS = sarq_pkg::FRAC_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      en,
    input  logic                                      in_valid,
    input  logic [2:0][sarq_pkg::COMP_W-1:0]          a_in,
    input  logic [2:0][sarq_pkg::COMP_W-1:0]          b_in,
    input  logic [15:0]                               min_length_sq,
    output logic                                      out_valid,
    output sarq_pkg::mag_vec_t                        out_mag,
    output logic [sarq_pkg::L2_W-1:0]                 out_l2,
    output sarq_pkg::side_t                           out_side
);
    import sarq_pkg::*;

    // Width that holds both |a|^2*|a+b|^2 and the scaled threshold.
    localparam int CMP_W = (2 * FRAC_BITS + 21 > 67) ? 2 * FRAC_BITS + 21 : 67;
    localparam logic [31:0] HALF = 32'(64'(1) << (FRAC_BITS - 1));

    logic [7:0] v_reg;

    // Stage 1 registers: a and s = a + b.
    logic signed [15:0] a1_reg [3];
    logic signed [16:0] s1_reg [3];

    // Stage 2 registers: products.
    logic signed [32:0] as2_reg [3][3];
    logic [32:0]        ss2_reg [3];
    logic [30:0]        aq2_reg [3];
    logic signed [15:0] a2_reg  [3];

    // Stage 3 registers: cross and dot products, squared lengths.
    logic signed [34:0] c3_reg  [4];
    logic [33:0]        mm3_reg;
    logic [31:0]        aa3_reg;
    logic [30:0]        aq3_reg [3];
    logic signed [15:0] a3_reg  [3];

    // Stage 4 registers: branch choice and partial products.
    logic signed [34:0] c4_reg  [4];
    logic               normal4_reg;
    logic               fb_ok4_reg;
    logic [48:0]        pp_lo4_reg;
    logic [48:0]        pp_hi4_reg;

    // Stage 5 registers: magnitudes and flags.
    logic [33:0]        mag5_reg [4];
    side_t              side5_reg;

    // Stage 6 registers: scaled magnitudes.
    mag_vec_t           m6_reg;
    side_t              side6_reg;

    // Stage 7 registers: squares.
    logic [61:0]        sq7_reg [4];
    mag_vec_t           m7_reg;
    side_t              side7_reg;

    // Stage 8 registers: sum of squares.
    logic [L2_W-1:0]    l28_reg;
    mag_vec_t           m8_reg;
    side_t              side8_reg;

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[6:0], in_valid};
        end
    end

    // Stage 1: sum of the two vectors.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a1_reg[i] <= $signed(a_in[i]);
                s1_reg[i] <= $signed({a_in[i][15], a_in[i]})
                           + $signed({b_in[i][15], b_in[i]});
            end
        end
    end

    // Stage 2: all products of a and s, and the squares.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    as2_reg[i][j] <= 33'(a1_reg[i]) * 33'(s1_reg[j]);
                end
                ss2_reg[i] <= 33'($signed(34'(s1_reg[i]) * 34'(s1_reg[i])));
                aq2_reg[i] <= 31'($signed(32'(a1_reg[i]) * 32'(a1_reg[i])));
                a2_reg[i]  <= a1_reg[i];
            end
        end
    end

    // Stage 3: cross product a x s, dot product a.s and squared lengths.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c3_reg[0] <= 35'(as2_reg[1][2]) - 35'(as2_reg[2][1]);
            c3_reg[1] <= 35'(as2_reg[2][0]) - 35'(as2_reg[0][2]);
            c3_reg[2] <= 35'(as2_reg[0][1]) - 35'(as2_reg[1][0]);
            c3_reg[3] <= 35'(as2_reg[0][0]) + 35'(as2_reg[1][1]) + 35'(as2_reg[2][2]);
            mm3_reg   <= 34'(ss2_reg[0]) + 34'(ss2_reg[1]) + 34'(ss2_reg[2]);
            aa3_reg   <= 32'(aq2_reg[0]) + 32'(aq2_reg[1]) + 32'(aq2_reg[2]);
            aq3_reg   <= aq2_reg;
            a3_reg    <= a2_reg;
        end
    end

    // Stage 4: pick the normal or the fallback branch.
    logic [16:0]        a0_mag;
    logic               big_x;
    logic [31:0]        fb_l2;
    logic signed [34:0] c4_next [4];
    logic               normal4_next;

    always_comb
    begin
        a0_mag       = a3_reg[0][15] ? 17'(-(17'(a3_reg[0]))) : 17'(a3_reg[0]);
        big_x        = 32'(a0_mag) > HALF;
        normal4_next = mm3_reg > {16'd0, min_length_sq, 2'b00};
        if (normal4_next)
        begin
            c4_next = c3_reg;
        end
        else if (big_x)
        begin
            c4_next[0] = 35'(a3_reg[1]);
            c4_next[1] = -(35'(a3_reg[0]));
            c4_next[2] = '0;
            c4_next[3] = '0;
        end
        else
        begin
            c4_next[0] = '0;
            c4_next[1] = 35'(a3_reg[2]);
            c4_next[2] = -(35'(a3_reg[1]));
            c4_next[3] = '0;
        end
        fb_l2 = big_x ? 32'(aq3_reg[1]) + 32'(aq3_reg[0])
                      : 32'(aq3_reg[2]) + 32'(aq3_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c4_reg      <= c4_next;
            normal4_reg <= normal4_next;
            fb_ok4_reg  <= fb_l2 > {16'd0, min_length_sq};
            pp_lo4_reg  <= 49'(aa3_reg) * 49'(mm3_reg[16:0]);
            pp_hi4_reg  <= 49'(aa3_reg) * 49'(mm3_reg[33:17]);
        end
    end

    // Stage 5: exact length test and component magnitudes.
    logic [CMP_W-1:0] prod5;
    logic [CMP_W-1:0] thr5;

    always_comb
    begin
        prod5 = (CMP_W'(pp_hi4_reg) << 17) + CMP_W'(pp_lo4_reg);
        thr5  = CMP_W'(min_length_sq) << (2 + 2 * FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                mag5_reg[i]      <= c4_reg[i][34] ? 34'(-c4_reg[i]) : 34'(c4_reg[i]);
                side5_reg.neg[i] <= c4_reg[i][34];
            end
            side5_reg.anti <= !normal4_reg;
            side5_reg.ok   <= normal4_reg ? (prod5 > thr5) : fb_ok4_reg;
        end
    end

    // Stage 6: common right shift that brings every magnitude below 2^31.
    logic shift2;
    logic shift1;

    always_comb
    begin
        shift2 = 1'b0;
        shift1 = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            shift2 = shift2 | (mag5_reg[i][33:32] != 2'b00);
            shift1 = shift1 | mag5_reg[i][31];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (shift2)
                begin
                    m6_reg[i] <= mag5_reg[i][32:2];
                end
                else if (shift1)
                begin
                    m6_reg[i] <= mag5_reg[i][31:1];
                end
                else
                begin
                    m6_reg[i] <= mag5_reg[i][30:0];
                end
            end
            side6_reg <= side5_reg;
        end
    end

    // Stage 7: squares of the scaled magnitudes.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                sq7_reg[i] <= 62'(m6_reg[i]) * 62'(m6_reg[i]);
            end
            m7_reg    <= m6_reg;
            side7_reg <= side6_reg;
        end
    end

    // Stage 8: sum of squares.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l28_reg   <= L2_W'(sq7_reg[0]) + L2_W'(sq7_reg[1])
                       + L2_W'(sq7_reg[2]) + L2_W'(sq7_reg[3]);
            m8_reg    <= m7_reg;
            side8_reg <= side7_reg;
        end
    end

    assign out_valid = v_reg[7];
    assign out_mag   = m8_reg;
    assign out_l2    = l28_reg;
    assign out_side  = side8_reg;

endmodule

// ----- src/sarq_sqrt.sv -----
// ============================================================================
// sarq_sqrt
// Pipelined integer square root, one result bit per stage.
// ============================================================================
module sarq_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [sarq_pkg::L2_W-1:0]      in_l2,
    input  sarq_pkg::mag_vec_t             in_mag,
    input  sarq_pkg::side_t                in_side,
    output logic                           out_valid,
    output logic [sarq_pkg::ROOT_W-1:0]    out_len,
    output sarq_pkg::mag_vec_t             out_mag,
    output sarq_pkg::side_t                out_side
);
    import sarq_pkg::*;

    localparam int NS = ROOT_W;

    logic [NS-1:0]   v_reg;
    logic [L2_W-1:0] x_reg   [NS];
    logic [L2_W-1:0] r_reg   [NS];
    mag_vec_t        m_reg   [NS];
    side_t           side_reg[NS];

    logic [L2_W-1:0] x_next  [NS];
    logic [L2_W-1:0] r_next  [NS];

    // One trial subtraction per stage, from the top pair of bits down.
    always_comb
    begin
        logic [L2_W-1:0] xi;
        logic [L2_W-1:0] ri;
        logic [L2_W-1:0] trial;
        logic [L2_W-1:0] bitv;
        for (int i = 0; i < NS; i++)
        begin
            xi    = (i == 0) ? in_l2 : x_reg[(i == 0) ? 0 : i - 1];
            ri    = (i == 0) ? '0 : r_reg[(i == 0) ? 0 : i - 1];
            bitv  = L2_W'(1) << (L2_W - 2 - 2 * i);
            trial = ri + bitv;
            if (xi >= trial)
            begin
                x_next[i] = xi - trial;
                r_next[i] = (ri >> 1) + bitv;
            end
            else
            begin
                x_next[i] = xi;
                r_next[i] = ri >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg       <= x_next;
            r_reg       <= r_next;
            m_reg[0]    <= in_mag;
            side_reg[0] <= in_side;
            for (int i = 1; i < NS; i++)
            begin
                m_reg[i]    <= m_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_len   = r_reg[NS-1][ROOT_W-1:0];
    assign out_mag   = m_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

// ----- src/sarq_div.sv -----
// ============================================================================
// sarq_div
// Four-lane restoring divider: round(mag * 2^FRAC_BITS / len), one quotient
// bit per stage after a stage that forms the rounded numerator.
// ============================================================================
module sarq_div #(
    parameter int FRAC_BITS = sarq_pkg::FRAC_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      en,
    input  logic                                      in_valid,
    input  logic [sarq_pkg::ROOT_W-1:0]               in_len,
    input  sarq_pkg::mag_vec_t                        in_mag,
    input  sarq_pkg::side_t                           in_side,
    output logic                                      out_valid,
    output logic [sarq_pkg::NUM_LANES-1:0][FRAC_BITS:0] out_quot,
    output logic                                      out_len_zero,
    output sarq_pkg::side_t                           out_side
);
    import sarq_pkg::*;

    localparam int DIV_W = FRAC_BITS + ROOT_W + 1;
    localparam int NQ    = FRAC_BITS + 1;

    logic [NQ:0]                         v_reg;
    logic [NUM_LANES-1:0][DIV_W-1:0]     rem_reg [NQ+1];
    logic [NUM_LANES-1:0][NQ-1:0]        q_reg   [NQ+1];
    logic [ROOT_W-1:0]                   len_reg [NQ+1];
    side_t                               side_reg[NQ+1];

    logic [NUM_LANES-1:0][DIV_W-1:0]     rem_next[NQ];
    logic [NUM_LANES-1:0][NQ-1:0]        q_next  [NQ];

    // One quotient bit per stage, most significant first.
    always_comb
    begin
        logic [DIV_W-1:0] d;
        for (int i = 0; i < NQ; i++)
        begin
            d = DIV_W'(len_reg[i]) << (FRAC_BITS - i);
            for (int l = 0; l < NUM_LANES; l++)
            begin
                if (rem_reg[i][l] >= d)
                begin
                    rem_next[i][l] = rem_reg[i][l] - d;
                    q_next[i][l]   = q_reg[i][l] | (NQ'(1) << (FRAC_BITS - i));
                end
                else
                begin
                    rem_next[i][l] = rem_reg[i][l];
                    q_next[i][l]   = q_reg[i][l];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NQ-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Numerator with half the divisor added for rounding.
            for (int l = 0; l < NUM_LANES; l++)
            begin
                rem_reg[0][l] <= (DIV_W'(in_mag[l]) << FRAC_BITS) + DIV_W'(in_len >> 1);
            end
            q_reg[0]    <= '0;
            len_reg[0]  <= in_len;
            side_reg[0] <= in_side;
            for (int i = 1; i <= NQ; i++)
            begin
                rem_reg[i]  <= rem_next[i-1];
                q_reg[i]    <= q_next[i-1];
                len_reg[i]  <= len_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid    = v_reg[NQ];
    assign out_quot     = q_reg[NQ];
    assign out_len_zero = (len_reg[NQ] == '0);
    assign out_side     = side_reg[NQ];

endmodule

// ----- test/tb_shortest_arc_quaternion_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_shortest_arc_quaternion_unit
// Self-checking bench for the shortest-arc rotation quaternion pipeline.
// ============================================================================
// Vector pairs are pushed through the unit under random valid and stall
// patterns. Every accepted pair is run through a bit-exact fixed-point
// predictor, and each result is compared field by field with the oldest
// prediction. The threshold register is swept over several values,
// including both extremes, while the pipeline is empty.
module tb_shortest_arc_quaternion_unit;
    import sarq_pkg::*;

    localparam int FRAC = 14;
    localparam int LATENCY = 57;
    localparam int SETTLE = LATENCY + 15;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 600;

    typedef struct packed {
        logic [COMP_W-1:0] fx;
        logic [COMP_W-1:0] fy;
        logic [COMP_W-1:0] fz;
        logic [COMP_W-1:0] tx;
        logic [COMP_W-1:0] ty;
        logic [COMP_W-1:0] tz;
    } vec_pair_t;

    typedef struct packed {
        logic [COMP_W-1:0] x;
        logic [COMP_W-1:0] y;
        logic [COMP_W-1:0] z;
        logic [COMP_W-1:0] w;
        logic              anti;
    } quat_t;

    // Holds the quaternions still owed by the unit and checks each arrival.
    class quat_scoreboard;
        quat_t      owed_quats[$];
        logic [15:0] min_len_sq;
        int         errors;
        int         pairs_seen;
        int         quats_seen;
        int         anti_seen;
        int         zero_seen;

        function new();
            min_len_sq = 16'd1;
            errors = 0;
            pairs_seen = 0;
            quats_seen = 0;
            anti_seen = 0;
            zero_seen = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // Exact integer version of the shortest-arc construction.
        function quat_t rotation_between(vec_pair_t p);
            longint a[3];
            longint s[3];
            longint c[4];
            longint unsigned mm;
            longint unsigned aa;
            longint unsigned thr;
            longint unsigned l2;
            longint unsigned m[4];
            longint unsigned mx;
            longint unsigned len;
            longint unsigned r;
            longint unsigned lim;
            longint unsigned one;
            longint unsigned rem;
            longint unsigned bitv;
            logic [127:0] prod;
            logic [127:0] bound;
            int k;
            bit ok;
            quat_t q;
            a[0] = $signed(p.fx);
            a[1] = $signed(p.fy);
            a[2] = $signed(p.fz);
            s[0] = a[0] + longint'($signed(p.tx));
            s[1] = a[1] + longint'($signed(p.ty));
            s[2] = a[2] + longint'($signed(p.tz));
            mm = 0;
            for (int i = 0; i < 3; i++)
                mm += s[i] * s[i];
            thr = min_len_sq;
            q = '0;
            if (mm > 4 * thr)
            begin
                c[0] = a[1] * s[2] - a[2] * s[1];
                c[1] = a[2] * s[0] - a[0] * s[2];
                c[2] = a[0] * s[1] - a[1] * s[0];
                c[3] = a[0] * s[0] + a[1] * s[1] + a[2] * s[2];
                aa = 0;
                for (int i = 0; i < 3; i++)
                    aa += a[i] * a[i];
                prod = 128'(aa) * 128'(mm);
                bound = 128'(4 * thr) << (2 * FRAC);
                ok = prod > bound;
            end
            else
            begin
                // Opposite vectors: pick an axis perpendicular to the first one.
                q.anti = 1'b1;
                if ((a[0] < 0 ? -a[0] : a[0]) > (longint'(1) << (FRAC - 1)))
                begin
                    c[0] = a[1];
                    c[1] = -a[0];
                    c[2] = 0;
                end
                else
                begin
                    c[0] = 0;
                    c[1] = a[2];
                    c[2] = -a[1];
                end
                c[3] = 0;
                l2 = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
                ok = l2 > thr;
            end
            if (!ok)
                return q;
            // Normalize: common shift, integer root, rounded quotient.
            one = longint'(1) << FRAC;
            mx = 0;
            for (int i = 0; i < 4; i++)
            begin
                m[i] = c[i] < 0 ? -c[i] : c[i];
                if (m[i] > mx)
                    mx = m[i];
            end
            k = 0;
            while ((mx >> k) >= (longint'(1) << 31))
                k++;
            l2 = 0;
            for (int i = 0; i < 4; i++)
            begin
                m[i] = m[i] >> k;
                l2 += m[i] * m[i];
            end
            rem = l2;
            len = 0;
            bitv = longint'(1) << 62;
            while (bitv > rem)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (rem >= len + bitv)
                begin
                    rem = rem - (len + bitv);
                    len = (len >> 1) + bitv;
                end
                else
                    len = len >> 1;
                bitv = bitv >> 2;
            end
            if (len == 0)
                return q;
            for (int i = 0; i < 4; i++)
            begin
                r = (m[i] * one + len / 2) / len;
                if (r > one)
                    r = one;
                lim = c[i] < 0 ? 32768 : 32767;
                if (r > lim)
                    r = lim;
                c[i] = c[i] < 0 ? -longint'(r) : longint'(r);
            end
            q.x = c[0][15:0];
            q.y = c[1][15:0];
            q.z = c[2][15:0];
            q.w = c[3][15:0];
            return q;
        endfunction

        function void note_pair(vec_pair_t p);
            owed_quats.push_back(rotation_between(p));
            pairs_seen++;
        endfunction

        task check_quat(quat_t got);
            quat_t want;
            quats_seen++;
            if (owed_quats.size() == 0)
            begin
                report($sformatf("quaternion %h arrived with none owed", got));
                return;
            end
            want = owed_quats.pop_front();
            if (got.anti)
                anti_seen++;
            if (got.x == 0 && got.y == 0 && got.z == 0 && got.w == 0)
                zero_seen++;
            if (got.x !== want.x)
                report($sformatf("quat_x got %h want %h", got.x, want.x));
            if (got.y !== want.y)
                report($sformatf("quat_y got %h want %h", got.y, want.y));
            if (got.z !== want.z)
                report($sformatf("quat_z got %h want %h", got.z, want.z));
            if (got.w !== want.w)
                report($sformatf("quat_w got %h want %h", got.w, want.w));
            if (got.anti !== want.anti)
                report($sformatf("anti_parallel got %b want %b", got.anti, want.anti));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [15:0] from_x = '0;
    logic [15:0] from_y = '0;
    logic [15:0] from_z = '0;
    logic [15:0] to_x = '0;
    logic [15:0] to_y = '0;
    logic [15:0] to_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [15:0] quat_x;
    logic [15:0] quat_y;
    logic [15:0] quat_z;
    logic [15:0] quat_w;
    logic anti_parallel;

    quat_scoreboard sb = new();
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;
    int thresholds_used = 1;

    shortest_arc_quaternion_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .from_x        (from_x),
        .from_y        (from_y),
        .from_z        (from_z),
        .to_x          (to_x),
        .to_y          (to_y),
        .to_z          (to_z),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .quat_x        (quat_x),
        .quat_y        (quat_y),
        .quat_z        (quat_z),
        .quat_w        (quat_w),
        .anti_parallel (anti_parallel)
    );

    always #5 clk = ~clk;

    // Result side: take results, pick the next stall, and watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_quat('{quat_x, quat_y, quat_z, quat_w, anti_parallel});
            if ((out_valid && !out_stall) || (in_valid && !in_stall) || cfg_wr_en)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", quiet_cycles);
                $display("tb_shortest_arc_quaternion_unit: done, errors");
                $finish;
            end
            else if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Offer one pair and hold it until the unit takes it.
    task send_pair(vec_pair_t p);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        from_x <= p.fx;
        from_y <= p.fy;
        from_z <= p.fz;
        to_x <= p.tx;
        to_y <= p.ty;
        to_z <= p.tz;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_pair(p);
    endtask

    task wait_drained();
        in_valid <= 1'b0;
        while (sb.owed_quats.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task write_threshold(logic [15:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.min_len_sq = value;
        thresholds_used++;
    endtask

    function automatic vec_pair_t make_pair(int ax, int ay, int az, int bx, int by, int bz);
        vec_pair_t p;
        p.fx = 16'(ax);
        p.fy = 16'(ay);
        p.fz = 16'(az);
        p.tx = 16'(bx);
        p.ty = 16'(by);
        p.tz = 16'(bz);
        return p;
    endfunction

    // Mostly unit-scale directions, with opposite pairs, tiny and raw words mixed in.
    function automatic vec_pair_t random_pair();
        vec_pair_t p;
        int kind;
        int ax;
        int ay;
        int az;
        kind = $urandom_range(9);
        ax = $urandom_range(32768) - 16384;
        ay = $urandom_range(32768) - 16384;
        az = $urandom_range(32768) - 16384;
        unique case (kind)
            0, 1, 2, 3:
                p = make_pair(ax, ay, az, $urandom_range(32768) - 16384,
                              $urandom_range(32768) - 16384, $urandom_range(32768) - 16384);
            4, 5:
                p = make_pair(ax, ay, az, -ax + $urandom_range(2) - 1,
                              -ay + $urandom_range(2) - 1, -az + $urandom_range(2) - 1);
            6:
                p = make_pair(ax, ay, az, -ax + $urandom_range(64) - 32,
                              -ay + $urandom_range(64) - 32, -az);
            7:
                p = make_pair($urandom_range(8) - 4, $urandom_range(8) - 4,
                              $urandom_range(8) - 4, $urandom_range(8) - 4,
                              $urandom_range(8) - 4, $urandom_range(8) - 4);
            default:
                p = {$urandom(), $urandom(), $urandom()};
        endcase
        return p;
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pairs at reset threshold.
        send_pair(make_pair(0, 0, 0, 0, 0, 0));
        send_pair(make_pair(16384, 0, 0, 16384, 0, 0));
        send_pair(make_pair(16384, 0, 0, 0, 16384, 0));
        send_pair(make_pair(16384, 0, 0, -16384, 0, 0));
        send_pair(make_pair(0, 16384, 0, 0, -16384, 0));
        send_pair(make_pair(0, 0, 16384, 0, 0, -16384));
        send_pair(make_pair(8192, 0, 14189, -8192, 0, -14189));
        send_pair(make_pair(8193, 0, 14188, -8193, 0, -14188));
        send_pair(make_pair(-8193, 5, 14188, 8193, -5, -14188));
        send_pair(make_pair(-32768, -32768, -32768, 32767, 32767, 32767));
        send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768));
        send_pair(make_pair(32767, -32768, 32767, -32768, 32767, -32768));
        send_pair(make_pair(-32768, 32767, 0, 0, -32768, 32767));
        send_pair(make_pair(1, 0, 0, 0, 1, 0));
        send_pair(make_pair(1, 1, 1, -1, -1, -1));
        send_pair(make_pair(16384, 0, 0, -16380, 10, 0));
        send_pair(make_pair(11585, 11585, 0, -11585, -11585, 0));
        send_pair(make_pair(9459, -9459, 9459, 16384, 0, 0));

        // Threshold extremes on a few directed pairs.
        write_threshold(16'd0);
        send_pair(make_pair(1, 0, 0, 0, 1, 0));
        send_pair(make_pair(0, 1, 0, 0, -1, 0));
        write_threshold(16'hFFFF);
        send_pair(make_pair(1, 0, 0, 0, 1, 0));
        send_pair(make_pair(100, 50, 0, 0, 100, 0));
        send_pair(make_pair(0, 200, 100, 0, -200, -100));

        // Receiver idles more than the sender.
        write_threshold(16'd1);
        tx_idle_pct = 35;
        rx_idle_pct = 51;
        for (int i = 0; i < RANDOM_ITEMS / 4; i++)
            send_pair(random_pair());

        // Sender idles more; then a long hold-off while the sender keeps offering.
        write_threshold(16'd0);
        tx_idle_pct = 51;
        rx_idle_pct = 35;
        for (int i = 0; i < RANDOM_ITEMS / 4; i++)
            send_pair(random_pair());
        tx_idle_pct = 0;
        hold_cycles = 300;
        for (int i = 0; i < 100; i++)
            send_pair(random_pair());

        // Sender waits for the pipeline to empty, then no idling on either side.
        in_valid <= 1'b0;
        while (sb.owed_quats.size() != 0)
            @(posedge clk);
        rx_idle_pct = 0;
        write_threshold(16'hFFFF);
        for (int i = 0; i < RANDOM_ITEMS / 4; i++)
            send_pair(random_pair());

        write_threshold(16'($urandom()));
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        for (int i = 0; i < RANDOM_ITEMS / 4 - 100; i++)
            send_pair(random_pair());

        wait_drained();
        $display("covered %0d pairs, %0d quaternions, %0d opposite-vector, %0d degenerate",
                 sb.pairs_seen, sb.quats_seen, sb.anti_seen, sb.zero_seen);
        $display("threshold settings used: %0d, mismatches: %0d", thresholds_used, sb.errors);
        if (sb.errors == 0)
            $display("tb_shortest_arc_quaternion_unit: done, clean");
        else
            $display("tb_shortest_arc_quaternion_unit: done, errors");
        $finish;
    end
endmodule
